[design/smr_pkg.sv]
// Package: shared types and codes for the square outline mask rasterizer.
package smr_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd3;

    localparam logic signed [31:0] ORIGIN_RESET = -32'sd10000;
    localparam logic [30:0]        EXTENT_RESET = 31'd20000;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_R
    } sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DRAW_INIT,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_READ_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        radius;
        logic [10:0]        word_addr;
    } in_item_t;

    typedef struct packed {
        logic [31:0] mask_word;
        logic        read_valid;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic clr_start;
        logic clr_step;
        logic map_mul;
        logic div_start;
        logic map_store;
        sel_t sel;
        logic draw_init;
        logic draw_rd;
        logic draw_wr;
        logic read_rd;
        logic res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] item_cmd;
        logic       clr_last;
        logic       div_done;
        logic       draw_last;
        logic       res_free;
    } ctrl_stat_t;

endpackage

[design/smr_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module smr_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

[design/smr_datapath.sv]
// Datapath: config registers, coordinate mapping, mask memory and result register.
module smr_datapath #(
    parameter int TEX_SIZE = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  smr_pkg::in_item_t                item,
    input  logic                             cfg_valid,
    input  logic [smr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    input  smr_pkg::ctrl_cmd_t               cmd,
    output smr_pkg::ctrl_stat_t              stat,
    input  logic                             result_stall,
    output logic                             result_valid,
    output smr_pkg::out_item_t               result
);

    localparam int WPR         = (TEX_SIZE + 31) / 32;
    localparam int STORE_DEPTH = TEX_SIZE * WPR;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = $clog2(TEX_SIZE);
    localparam int CW          = PIX_W + 2;
    localparam int WCOL_W      = (PIX_W > 5) ? PIX_W - 5 : 1;
    localparam int MUL_W       = $clog2(2 * TEX_SIZE + 1);
    localparam int PROD_W      = 33 + MUL_W;
    localparam logic [MUL_W-1:0]     TWO_T = MUL_W'(2 * TEX_SIZE);
    localparam logic signed [CW-1:0] TMAX  = CW'(TEX_SIZE - 1);
    localparam logic signed [CW-1:0] TSIZE = CW'(TEX_SIZE);

    // configuration
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [30:0]        extent_x_reg;
    logic [30:0]        extent_y_reg;

    // captured item
    logic [1:0]         item_cmd_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [30:0]        rad_reg;
    logic [10:0]        addr_reg;

    // mapping
    logic signed [PROD_W-1:0] prod_reg;
    logic [PIX_W-1:0]         cx_reg;
    logic [PIX_W-1:0]         cy_reg;
    logic [PIX_W-1:0]         h_reg;

    // draw walk
    logic [PIX_W-1:0]  row_reg;
    logic [WCOL_W-1:0] w_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // memory
    logic [31:0] mem [STORE_DEPTH];
    logic [31:0] rdata_reg;

    logic               result_valid_reg;
    smr_pkg::out_item_t result_reg;

    logic signed [32:0]       d_sel;
    logic [30:0]              e_raw;
    logic [30:0]              e_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W:0]   num_s;
    logic [PROD_W-1:0]        num_mag;
    logic                     div_done;
    logic [PROD_W-1:0]        quo;
    logic [PIX_W-1:0]         q_clamp;

    logic signed [CW-1:0] x0, x1, y0, y1, xlo, xhi, ylo, yhi, row_s;
    logic [WCOL_W-1:0]    wlo, whi;
    logic                 edge_row;
    logic signed [CW-1:0] col_base;
    logic signed [CW-1:0] col;
    logic [31:0]          bit_mask;
    logic [ADDR_W-1:0]    draw_addr;
    logic [ADDR_W-1:0]    read_addr;
    logic                 addr_in_range;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [31:0]          mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    // ---------------- mapping ----------------
    always_comb
    begin
        case (cmd.sel)
            smr_pkg::SEL_X:
            begin
                d_sel = dx_reg;
                e_raw = extent_x_reg;
            end
            smr_pkg::SEL_Y:
            begin
                d_sel = dy_reg;
                e_raw = extent_y_reg;
            end
            smr_pkg::SEL_R:
            begin
                d_sel = $signed({2'b00, rad_reg});
                e_raw = extent_x_reg;
            end
            default:
            begin
                d_sel = '0;
                e_raw = extent_x_reg;
            end
        endcase
        e_sel     = (e_raw == '0) ? 31'd1 : e_raw;
        prod_next = PROD_W'(d_sel) * $signed(PROD_W'(TWO_T));
        num_s     = (PROD_W+1)'(prod_reg) + $signed((PROD_W+1)'(e_sel));
        num_mag   = num_s[PROD_W] ? '0 : num_s[PROD_W-1:0];
    end

    smr_div #(
        .NUM_W (PROD_W),
        .DEN_W (32)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_mag),
        .den   ({e_sel, 1'b0}),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        if (quo > PROD_W'(TEX_SIZE - 1))
        begin
            q_clamp = PIX_W'(TEX_SIZE - 1);
        end
        else if ((cmd.sel == smr_pkg::SEL_R) && (quo == '0))
        begin
            q_clamp = PIX_W'(1);
        end
        else
        begin
            q_clamp = quo[PIX_W-1:0];
        end
    end

    // ---------------- draw geometry ----------------
    always_comb
    begin
        x0  = $signed(CW'(cx_reg)) - $signed(CW'(h_reg));
        x1  = $signed(CW'(cx_reg)) + $signed(CW'(h_reg));
        y0  = $signed(CW'(cy_reg)) - $signed(CW'(h_reg));
        y1  = $signed(CW'(cy_reg)) + $signed(CW'(h_reg));
        xlo = (x0 < 0) ? '0 : x0;
        xhi = (x1 > TMAX) ? TMAX : x1;
        ylo = (y0 < 0) ? '0 : y0;
        yhi = (y1 > TMAX) ? TMAX : y1;
        wlo = WCOL_W'(xlo >>> 5);
        whi = WCOL_W'(xhi >>> 5);
        row_s    = $signed(CW'(row_reg));
        edge_row = (row_s == y0) || (row_s == y1);
        col_base = $signed(CW'({w_reg, 5'd0}));
    end

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            col = col_base + $signed(CW'(i));
            bit_mask[i] = (col < TSIZE) &&
                          ((edge_row && (col >= xlo) && (col <= xhi)) ||
                           (col == x0) || (col == x1));
        end
        if (bit_mask == '1)
        begin
            col = col_base;
        end
    end

    assign draw_addr     = ADDR_W'(row_reg) * ADDR_W'(WPR) + ADDR_W'(w_reg);
    assign read_addr     = ADDR_W'(addr_reg);
    assign addr_in_range = (32'(addr_reg) < 32'(STORE_DEPTH));

    // ---------------- memory ----------------
    always_comb
    begin
        mem_we    = cmd.clr_step || cmd.draw_wr;
        mem_waddr = cmd.clr_step ? clr_addr_reg : draw_addr;
        mem_wdata = cmd.clr_step ? 32'd0 : (rdata_reg | bit_mask);
        mem_re    = cmd.draw_rd || cmd.read_rd;
        mem_raddr = cmd.read_rd ? read_addr : draw_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= smr_pkg::ORIGIN_RESET;
            origin_y_reg     <= smr_pkg::ORIGIN_RESET;
            extent_x_reg     <= smr_pkg::EXTENT_RESET;
            extent_y_reg     <= smr_pkg::EXTENT_RESET;
            clr_addr_reg     <= '0;
            row_reg          <= '0;
            w_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    smr_pkg::CFG_ORIGIN_X: origin_x_reg <= $signed(cfg_data);
                    smr_pkg::CFG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data);
                    smr_pkg::CFG_EXTENT_X: extent_x_reg <= cfg_data[30:0];
                    smr_pkg::CFG_EXTENT_Y: extent_y_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end

            if (cmd.draw_init)
            begin
                row_reg <= PIX_W'(ylo);
                w_reg   <= wlo;
            end
            else if (cmd.draw_wr)
            begin
                if (w_reg == whi)
                begin
                    row_reg <= row_reg + PIX_W'(1);
                    w_reg   <= wlo;
                end
                else if (edge_row)
                begin
                    w_reg <= w_reg + WCOL_W'(1);
                end
                else
                begin
                    w_reg <= whi;
                end
            end

            if (cmd.res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_cmd_reg <= item.cmd;
            dx_reg       <= 33'(item.pos_x) - 33'(origin_x_reg);
            dy_reg       <= 33'(item.pos_y) - 33'(origin_y_reg);
            rad_reg      <= item.radius;
            addr_reg     <= item.word_addr;
        end
        if (cmd.map_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.map_store)
        begin
            case (cmd.sel)
                smr_pkg::SEL_X: cx_reg <= q_clamp;
                smr_pkg::SEL_Y: cy_reg <= q_clamp;
                smr_pkg::SEL_R: h_reg  <= q_clamp;
                default: ;
            endcase
        end
        if (cmd.res_load)
        begin
            result_reg.read_valid <= (item_cmd_reg == smr_pkg::CMD_READ);
            result_reg.mask_word  <= ((item_cmd_reg == smr_pkg::CMD_READ) && addr_in_range) ?
                                     rdata_reg : 32'd0;
        end
    end

    always_comb
    begin
        stat.item_cmd  = item_cmd_reg;
        stat.clr_last  = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
        stat.div_done  = div_done;
        stat.draw_last = (w_reg == whi) && (row_s == yhi);
        stat.res_free  = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_rd |-> (row_s >= ylo) && (row_s <= yhi) && (w_reg >= wlo) && (w_reg <= whi))
        else $error("draw walk left the clipped box");
    a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_wr |-> $past(cmd.draw_rd))
        else $error("mask write without preceding read");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.res_free)
        else $error("result overwritten before transfer");
`endif

endmodule

[design/smr_ctrl.sv]
// Controller: sequences clear, map, draw and read operations over the datapath.
module smr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  smr_pkg::ctrl_stat_t stat,
    output smr_pkg::ctrl_cmd_t  cmd
);

    smr_pkg::state_t state_reg;
    smr_pkg::state_t state_next;
    smr_pkg::sel_t   sel_reg;
    smr_pkg::sel_t   sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smr_pkg::ST_INIT;
            sel_reg   <= smr_pkg::SEL_X;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            smr_pkg::ST_INIT:
            begin
                if (stat.clr_last)
                begin
                    state_next = smr_pkg::ST_IDLE;
                end
            end
            smr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = smr_pkg::ST_DECODE;
                end
            end
            smr_pkg::ST_DECODE:
            begin
                sel_next = smr_pkg::SEL_X;
                case (stat.item_cmd)
                    smr_pkg::CMD_CLEAR: state_next = smr_pkg::ST_CLEAR;
                    smr_pkg::CMD_DRAW:  state_next = smr_pkg::ST_MUL;
                    smr_pkg::CMD_READ:  state_next = smr_pkg::ST_READ_RD;
                    default:            state_next = smr_pkg::ST_DONE;
                endcase
            end
            smr_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = smr_pkg::ST_DONE;
                end
            end
            smr_pkg::ST_MUL:
            begin
                state_next = smr_pkg::ST_DIV_GO;
            end
            smr_pkg::ST_DIV_GO:
            begin
                state_next = smr_pkg::ST_DIV_WAIT;
            end
            smr_pkg::ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    case (sel_reg)
                        smr_pkg::SEL_X:
                        begin
                            sel_next   = smr_pkg::SEL_Y;
                            state_next = smr_pkg::ST_MUL;
                        end
                        smr_pkg::SEL_Y:
                        begin
                            sel_next   = smr_pkg::SEL_R;
                            state_next = smr_pkg::ST_MUL;
                        end
                        default:
                        begin
                            state_next = smr_pkg::ST_DRAW_INIT;
                        end
                    endcase
                end
            end
            smr_pkg::ST_DRAW_INIT:
            begin
                state_next = smr_pkg::ST_DRAW_RD;
            end
            smr_pkg::ST_DRAW_RD:
            begin
                state_next = smr_pkg::ST_DRAW_WR;
            end
            smr_pkg::ST_DRAW_WR:
            begin
                state_next = stat.draw_last ? smr_pkg::ST_DONE : smr_pkg::ST_DRAW_RD;
            end
            smr_pkg::ST_READ_RD:
            begin
                state_next = smr_pkg::ST_DONE;
            end
            smr_pkg::ST_DONE:
            begin
                if (stat.res_free)
                begin
                    state_next = smr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = sel_reg;
        item_stall = 1'b1;
        case (state_reg)
            smr_pkg::ST_INIT:
            begin
                cmd.clr_step = 1'b1;
            end
            smr_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            smr_pkg::ST_DECODE:
            begin
                cmd.clr_start = 1'b1;
            end
            smr_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            smr_pkg::ST_MUL:
            begin
                cmd.map_mul = 1'b1;
            end
            smr_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
            end
            smr_pkg::ST_DIV_WAIT:
            begin
                cmd.map_store = stat.div_done;
            end
            smr_pkg::ST_DRAW_INIT:
            begin
                cmd.draw_init = 1'b1;
            end
            smr_pkg::ST_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
            end
            smr_pkg::ST_DRAW_WR:
            begin
                cmd.draw_wr = 1'b1;
            end
            smr_pkg::ST_READ_RD:
            begin
                cmd.read_rd = 1'b1;
            end
            smr_pkg::ST_DONE:
            begin
                cmd.res_load = stat.res_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/square_outline_mask_rasterizer.sv]
// Top level: square outline mask rasterizer, controller plus datapath.
//
//  channel  handshake              payload
//  item     item_valid/item_stall  item (cmd, pos_x, pos_y, radius, word_addr)
//  result   result_valid/stall     result (mask_word, read_valid)
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item at a time. Clear writes every word of the store, one word a cycle.
// Draw: 3 mapping divisions on the shared divider,
//   then a read and a write per word on the memory port (edge rows walk every word of the
//   clipped span, other rows at most two).
// After reset a clearing pass over all TEX_SIZE*WPR words runs before the first transfer.
// A stalled result holds the block in its final state; cfg is always ready.
module square_outline_mask_rasterizer #(
    parameter int TEX_SIZE = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  smr_pkg::in_item_t             item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output smr_pkg::out_item_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    smr_pkg::ctrl_cmd_t  cmd;
    smr_pkg::ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    smr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    smr_datapath #(
        .TEX_SIZE (TEX_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
